// ===== hw/rtl/rtlb_pkg.sv =====
package rtlb_pkg;

  // default table depth
  localparam int TABLE_SLOTS_DEF = 16;

  // field widths
  localparam int ID_W     = 32;
  localparam int SRC_W    = 16;
  localparam int TIME_W   = 32;
  localparam int BASE_W   = 20;
  localparam int ATT_W    = 4;
  localparam int KIND_W   = 4;
  localparam int MODE_W   = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 20;
  localparam int PROD_W   = BASE_W + ATT_W;

  // register reset values
  localparam logic [BASE_W-1:0] BASE_DELAY_RST    = BASE_W'(5000);
  localparam logic [ATT_W-1:0]  ATTEMPT_LIMIT_RST = ATT_W'(3);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = CFG_IDX_W'(1);

  // request modes; the fourth code is ignored
  localparam logic [MODE_W-1:0] MODE_TRACK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ACK   = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    K_RETRANSMIT = 4'd0,
    K_FAILED     = 4'd1,
    K_RELEASED   = 4'd2,
    K_TRACKED    = 4'd3,
    K_FILTERED   = 4'd4,
    K_FULL       = 4'd5,
    K_ACK_MATCH  = 4'd6,
    K_ACK_MISS   = 4'd7,
    K_SCAN_DONE  = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [SRC_W-1:0]  source;
    logic [ATT_W-1:0]  attempts;
    logic [TIME_W-1:0] due;
  } entry_t;

  // update of one slot: entry write and flag changes
  typedef struct packed {
    logic wr_en;
    logic set_active;
    logic clr_active;
    logic set_acked;
    logic clr_acked;
  } slot_op_t;

endpackage

// ===== hw/rtl/rtlb_table.sv =====
module rtlb_table
  import rtlb_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [SW-1:0]          rd_addr,
  output entry_t                 rd_data,
  input  logic [SW-1:0]          op_addr,
  input  slot_op_t               op,
  input  entry_t                 wr_data,
  output logic [TABLE_SLOTS-1:0] active,
  output logic [TABLE_SLOTS-1:0] acked
);

  entry_t mem [TABLE_SLOTS];

  // entry memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (op.wr_en) begin
      mem[op_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // per-slot flags, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
      acked  <= '0;
    end else begin
      if (op.set_active) active[op_addr] <= 1'b1;
      if (op.clr_active) active[op_addr] <= 1'b0;
      if (op.set_acked)  acked[op_addr]  <= 1'b1;
      if (op.clr_acked)  acked[op_addr]  <= 1'b0;
    end
  end

endmodule

// ===== hw/rtl/retry_table_linear_backoff_core.sv =====
// Retransmission timer table with linear backoff. Requests arrive one at a
// time: track, scan or acknowledgement, and the block takes no new request
// until the current one is finished; each mode but the unused one ends by
// handing its last result to the output register. Each request walks the
// table one slot per cycle through the single read port of the entry
// memory, unless the output side stalls a result: a track or
// acknowledgement visits slots up to the first hit (at most TABLE_SLOTS),
// and a scan visits every slot and ends with one scan-done result. A
// filtered track gives its result without walking, an unused mode gives
// none. Slot flags reset at once; entry contents are written in the same
// cycle a slot becomes active, so no clearing pass.
module retry_table_linear_backoff_core
  import rtlb_pkg::*;
#(
  parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DAT_W-1:0]  cfg_data,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [MODE_W-1:0]     mode,
  input  logic [ID_W-1:0]       msg_id,
  input  logic [SRC_W-1:0]      source_node,
  input  logic                  priority_high,
  input  logic                  dest_broadcast,
  input  logic [TIME_W-1:0]     now_ticks,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KIND_W-1:0]     result_kind,
  output logic [ID_W-1:0]       out_msg_id,
  output logic [SRC_W-1:0]      out_source_node,
  output logic [ATT_W-1:0]      attempt_number,
  output logic                  last_result
);

  localparam int SW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [SW-1:0] LAST_IDX = SW'(TABLE_SLOTS - 1);

  state_t state, state_next;

  logic [BASE_W-1:0] base_delay;
  logic [ATT_W-1:0]  attempt_limit;

  // latched request
  logic [MODE_W-1:0] cur_mode;
  logic [ID_W-1:0]   cur_id;
  logic [SRC_W-1:0]  cur_src;
  logic              cur_prio;
  logic              cur_bcast;
  logic [TIME_W-1:0] cur_now;

  logic [SW-1:0]          idx;
  logic [SW-1:0]          rd_addr;
  entry_t                 rd_data;
  entry_t                 wr_data;
  slot_op_t               op;
  logic [TABLE_SLOTS-1:0] active;
  logic [TABLE_SLOTS-1:0] acked;

  logic              in_acc;
  logic              emit_ok;
  logic              emit;
  kind_t             emit_kind;
  logic [ID_W-1:0]   emit_id;
  logic [SRC_W-1:0]  emit_src;
  logic [ATT_W-1:0]  emit_att;
  logic              emit_last;
  logic              adv;
  logic              fin;
  logic              last_slot;
  logic              key_hit;
  logic              is_due;
  logic [ATT_W-1:0]  att_inc;
  logic [PROD_W-1:0] delay;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign emit_ok   = !out_valid || !out_stall;
  assign last_slot = (idx == LAST_IDX);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay    <= BASE_DELAY_RST;
      attempt_limit <= ATTEMPT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_BASE_DELAY) begin
        base_delay <= cfg_data;
      end else if (cfg_index == REG_ATTEMPT_LIMIT) begin
        attempt_limit <= cfg_data[ATT_W-1:0];
      end
    end
  end

  // capture request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_mode  <= mode;
      cur_id    <= msg_id;
      cur_src   <= source_node;
      cur_prio  <= priority_high;
      cur_bcast <= dest_broadcast;
      cur_now   <= now_ticks;
    end
  end

  // slot decode
  assign key_hit = active[idx] && (rd_data.id == cur_id) && (rd_data.source == cur_src);
  assign is_due  = active[idx] && (cur_now >= rd_data.due);
  assign att_inc = rd_data.attempts + ATT_W'(1);
  assign delay   = PROD_W'(base_delay) * PROD_W'(att_inc);

  // per-cycle actions
  always_comb begin
    emit      = 1'b0;
    emit_kind = K_RETRANSMIT;
    emit_id   = cur_id;
    emit_src  = cur_src;
    emit_att  = '0;
    emit_last = 1'b0;
    adv       = 1'b0;
    fin       = 1'b0;
    op        = '0;
    wr_data   = rd_data;
    unique case (state)
      ST_IDLE: begin
      end
      ST_EVAL: begin
        case (cur_mode)
          MODE_TRACK: begin
            wr_data.id       = cur_id;
            wr_data.source   = cur_src;
            wr_data.attempts = ATT_W'(1);
            wr_data.due      = cur_now + TIME_W'(base_delay);
            if (!cur_prio || cur_bcast) begin
              emit      = 1'b1;
              emit_kind = K_FILTERED;
              emit_last = 1'b1;
              fin       = emit_ok;
            end else if (!active[idx]) begin
              emit          = 1'b1;
              emit_kind     = K_TRACKED;
              emit_att      = ATT_W'(1);
              emit_last     = 1'b1;
              fin           = emit_ok;
              op.wr_en      = emit_ok;
              op.set_active = emit_ok;
              op.clr_acked  = emit_ok;
            end else if (last_slot) begin
              emit      = 1'b1;
              emit_kind = K_FULL;
              emit_last = 1'b1;
              fin       = emit_ok;
            end else begin
              adv = 1'b1;
            end
          end
          MODE_ACK: begin
            if (key_hit) begin
              emit         = 1'b1;
              emit_kind    = K_ACK_MATCH;
              emit_att     = rd_data.attempts;
              emit_last    = 1'b1;
              fin          = emit_ok;
              op.set_acked = emit_ok;
            end else if (last_slot) begin
              emit      = 1'b1;
              emit_kind = K_ACK_MISS;
              emit_last = 1'b1;
              fin       = emit_ok;
            end else begin
              adv = 1'b1;
            end
          end
          MODE_SCAN: begin
            emit_id  = rd_data.id;
            emit_src = rd_data.source;
            emit_att = rd_data.attempts;
            wr_data.attempts = att_inc;
            wr_data.due      = cur_now + TIME_W'(delay);
            if (is_due) begin
              emit = 1'b1;
              adv  = emit_ok;
              if (acked[idx]) begin
                emit_kind     = K_RELEASED;
                op.clr_active = emit_ok;
                op.clr_acked  = emit_ok;
              end else if (rd_data.attempts >= attempt_limit) begin
                emit_kind     = K_FAILED;
                op.clr_active = emit_ok;
              end else begin
                emit_kind = K_RETRANSMIT;
                emit_att  = att_inc;
                op.wr_en  = emit_ok;
              end
            end else begin
              adv = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ST_DONE: begin
        emit      = 1'b1;
        emit_kind = K_SCAN_DONE;
        emit_id   = '0;
        emit_src  = '0;
        emit_last = 1'b1;
        fin       = emit_ok;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_acc) state_next = ST_EVAL;
      ST_EVAL: begin
        if (fin) begin
          state_next = ST_IDLE;
        end else if (adv && last_slot) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: if (fin) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // slot walk; the read runs one slot ahead of the advance
  always_ff @(posedge clk) begin
    if (rst || in_acc) begin
      idx <= '0;
    end else if (state == ST_EVAL && adv && !last_slot) begin
      idx <= idx + SW'(1);
    end
  end

  always_comb begin
    if (state != ST_EVAL) begin
      rd_addr = '0;
    end else if (adv) begin
      rd_addr = last_slot ? '0 : idx + SW'(1);
    end else begin
      rd_addr = idx;
    end
  end

  rtlb_table #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .op_addr (idx),
    .op      (op),
    .wr_data (wr_data),
    .active  (active),
    .acked   (acked)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit && emit_ok) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit && emit_ok) begin
      result_kind     <= emit_kind;
      out_msg_id      <= emit_id;
      out_source_node <= emit_src;
      attempt_number  <= emit_att;
      last_result     <= emit_last;
    end
  end

  // a track only claims a free slot
  a_track_free: assert property (@(posedge clk) disable iff (rst)
    op.set_active |-> !active[idx])
    else $error("track claimed an active slot");

  // an ack only marks a live slot
  a_ack_live: assert property (@(posedge clk) disable iff (rst)
    op.set_acked |-> active[idx])
    else $error("ack marked an inactive slot");

  // leaving a request with a result leaves its final result in the output register
  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE && fin && emit) |=> (out_valid && last_result))
    else $error("request ended without final result");

  // a scan reaches the done state only after its last slot
  a_done_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && state_next == ST_DONE) |-> (cur_mode == MODE_SCAN && last_slot))
    else $error("bad entry to scan done");

endmodule
